// ===== rtl/lph_pkg.sv =====
// ----------------------------------------------------------------------------
// lph_pkg: shared types and constants of the linear probe hash table
// Table geometry, opcode and status codes, and the slot store write port.
// ----------------------------------------------------------------------------
package lph_pkg;

  // Table geometry (slot count is a power of two, so key mod size is a mask)
  localparam int unsigned TableSize = 16;
  localparam int unsigned SlotW     = $clog2(TableSize);
  localparam int unsigned KeyW      = 32;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned IndexW    = 4;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DELETED   = 3'd4,
    ST_INVALID   = 3'd5
  } status_e;

  // Write port into the slot store
  typedef struct packed {
    logic             en;
    logic [SlotW-1:0] addr;
    logic [KeyW-1:0]  data;
  } slot_wr_t;

endpackage

// ===== rtl/lph_req_if.sv =====
// ----------------------------------------------------------------------------
// lph_req_if: request channel
// Carries one opcode and key per transaction under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lph_req_if import lph_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OpW-1:0]      opcode;
  logic [KeyW-1:0]     key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

// ===== rtl/lph_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lph_rsp_if: response channel
// Carries one status and slot index per transaction under valid/ready.
// ----------------------------------------------------------------------------
interface lph_rsp_if import lph_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic [IndexW-1:0]   slot_index;

  modport source (output valid, output status, output slot_index, input ready);
  modport sink   (input valid, input status, input slot_index, output ready);
endinterface

// ===== rtl/linear_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open addressing hash table, linear probing
// Sixteen key slots; insert, search and delete by a one-slot-per-cycle probe.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries an opcode (insert, search, delete) and a 32-bit key; rsp_o
//   returns one status and slot index for every request transaction.
//   A request is taken only when the block is idle. The probe starts at the
//   key's home slot (low key bits) and visits one slot per cycle through a
//   single compare unit, stopping at the first match or after a sweep of all
//   sixteen slots. When the probe ends, the result is loaded into the output
//   register and the block returns to idle, so the next request is taken only
//   after the previous probe is through. A zero key or an unknown opcode
//   ends the probe on its first slot and answers invalid.
//   The response sits in an output register; the next request may be taken
//   while it waits. If the receiver stalls and a new result is ready, the
//   probe holds its final slot until the output register frees up, and the
//   table is updated only when the result is loaded.
//   Reset empties every slot, clears the response valid state and idles the probe.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lph_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lph_req_if.sink   req_i,
  lph_rsp_if.source rsp_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StProbe = 1'b1;

  localparam logic [SlotW-1:0] LastStep = SlotW'(TableSize - 1);

  logic             state_q, state_d;
  logic [SlotW-1:0] step_q, step_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [OpW-1:0]   op_q, op_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic             bad_q, bad_d;

  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [IndexW-1:0]  out_index_q, out_index_d;

  logic            req_fire;
  logic            out_free;
  logic [KeyW-1:0] rd_data;
  logic [KeyW-1:0] want;
  logic            hit;
  logic            finish;
  slot_wr_t        wr;

  lph_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // Shared compare: insert looks for an empty slot, the others for the key
  assign want   = (op_q == OP_INSERT) ? '0 : key_q;
  assign hit    = !bad_q && (rd_data == want);
  assign finish = bad_q || hit || (step_q == LastStep);

  // Sequencer, table update and result
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    idx_d        = idx_q;
    op_d         = op_q;
    key_d        = key_q;
    bad_d        = bad_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_index_d  = out_index_q;
    wr           = '{en: 1'b0, addr: idx_q, data: '0};

    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          op_d    = req_i.opcode;
          key_d   = req_i.key;
          idx_d   = req_i.key[SlotW-1:0];
          step_d  = '0;
          bad_d   = (req_i.key == '0) ||
                    !((req_i.opcode == OP_INSERT) || (req_i.opcode == OP_SEARCH) ||
                      (req_i.opcode == OP_DELETE));
          state_d = StProbe;
        end
      end
      StProbe: begin
        if (!finish) begin
          step_d = step_q + 1'b1;
          idx_d  = idx_q + 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_index_d = hit ? IndexW'(idx_q) : '0;
          if (bad_q) begin
            out_status_d = ST_INVALID;
          end else if (op_q == OP_INSERT) begin
            out_status_d = hit ? ST_INSERTED : ST_FULL;
            wr.en        = hit;
            wr.data      = key_q;
          end else if (op_q == OP_DELETE) begin
            out_status_d = hit ? ST_DELETED : ST_NOT_FOUND;
            wr.en        = hit;
          end else begin
            out_status_d = hit ? ST_FOUND : ST_NOT_FOUND;
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    step_q       <= step_d;
    idx_q        <= idx_d;
    op_q         <= op_d;
    key_q        <= key_d;
    bad_q        <= bad_d;
    out_status_q <= out_status_d;
    out_index_q  <= out_index_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.slot_index = out_index_q;

endmodule

// ===== rtl/lph_slot_store.sv =====
// ----------------------------------------------------------------------------
// lph_slot_store: key slot storage
// One key per slot, cleared to empty at reset, one read and one write port.
// ----------------------------------------------------------------------------
module lph_slot_store import lph_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slot_wr_t         wr_i,
  input  logic [SlotW-1:0] rd_addr_i,
  output logic [KeyW-1:0]  rd_data_o
);

  logic [KeyW-1:0] slot_q [TableSize];

  // Slot registers, all empty after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TableSize; i++) begin
        slot_q[i] <= '0;
      end
    end else if (wr_i.en) begin
      slot_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = slot_q[rd_addr_i];

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of linear_probe_hash_table
// Drives insert, search and delete requests through the request channel and
// predicts each response from a local copy of the slot table. Responses are
// compared in order, field by field. Both sides idle at random, and the
// receiver holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
  import lph_pkg::*;

  // Opcode with no meaning; the block answers invalid
  localparam logic [OpW-1:0] OpUndefined = 2'd3;
  localparam int unsigned    RandomItems = 1300;
  localparam int unsigned    KeyPoolSize = 24;
  localparam int unsigned    StallLimit  = 2000;
  localparam int unsigned    LongHold    = 400;
  localparam int unsigned    HoldAtRsp   = 200;
  localparam int unsigned    DrainCycles = 40;

  typedef struct {
    logic [OpW-1:0]  opcode;
    logic [KeyW-1:0] key;
    int unsigned     gap;
  } request_t;

  typedef struct {
    status_e           status;
    logic [IndexW-1:0] slot_index;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lph_req_if req_if ();
  lph_rsp_if rsp_if ();

  linear_probe_hash_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  request_t        request_q[$];
  outcome_t        outcome_q[$];
  logic [KeyW-1:0] slot_model[TableSize] = '{default: '0};
  logic [KeyW-1:0] key_pool[KeyPoolSize];
  int unsigned     errors      = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     req_idle;
  int unsigned     rsp_wait;
  int unsigned     rsp_count;
  bit              req_fast    = 1'b0;
  bit              rsp_fast    = 1'b0;

  // Predicted outcome of one request; updates the local slot table
  function automatic outcome_t apply_request(input logic [OpW-1:0] opcode,
                                             input logic [KeyW-1:0] key);
    outcome_t        res;
    logic [KeyW-1:0] want;
    int unsigned     idx;
    bit              hit;
    res.status     = ST_INVALID;
    res.slot_index = '0;
    hit            = 1'b0;
    idx            = 0;
    if (key == '0 || opcode == OpUndefined) return res;
    // insert looks for an empty slot, search and delete for the key itself
    want = (opcode == OP_INSERT) ? '0 : key;
    for (int unsigned step = 0; step < TableSize && !hit; step++) begin
      idx = (key % TableSize + step) % TableSize;
      if (slot_model[idx] == want) hit = 1'b1;
    end
    if (opcode == OP_INSERT) begin
      res.status = hit ? ST_INSERTED : ST_FULL;
      if (hit) slot_model[idx] = key;
    end else if (!hit) begin
      res.status = ST_NOT_FOUND;
    end else if (opcode == OP_DELETE) begin
      res.status = ST_DELETED;
      slot_model[idx] = '0;
    end else begin
      res.status = ST_FOUND;
    end
    if (hit) res.slot_index = idx[IndexW-1:0];
    return res;
  endfunction

  function automatic void add_request(input logic [OpW-1:0] opcode,
                                      input logic [KeyW-1:0] key);
    request_t item;
    item.opcode = opcode;
    item.key    = key;
    item.gap    = req_fast ? 0 : $urandom_range(0, 16);
    request_q.push_back(item);
  endfunction

  // Response idle draw: bursts with no gaps now and then
  function automatic int unsigned draw_rsp_wait();
    if ($urandom_range(0, 49) == 0) rsp_fast = !rsp_fast;
    return rsp_fast ? 0 : $urandom_range(0, 16);
  endfunction

  // Request driver: pops pending requests, predicts on each transaction
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    request_t item;
    bit       take_next;
    if (!rst_ni) begin
      req_if.valid  <= 1'b0;
      req_if.opcode <= '0;
      req_if.key    <= '0;
      req_idle      <= 0;
    end else begin
      take_next = !req_if.valid || req_if.ready;
      if (req_if.valid && req_if.ready)
        outcome_q.push_back(apply_request(req_if.opcode, req_if.key));
      if (take_next) begin
        if (request_q.size() == 0) begin
          req_if.valid <= 1'b0;
        end else if (req_idle < request_q[0].gap) begin
          req_if.valid <= 1'b0;
          req_idle     <= req_idle + 1;
        end else begin
          item          = request_q.pop_front();
          req_if.valid  <= 1'b1;
          req_if.opcode <= item.opcode;
          req_if.key    <= item.key;
          req_idle      <= 0;
        end
      end
    end
  end

  // Response monitor: checks each transaction, draws the next hold-off
  always @(posedge clk_i or negedge rst_ni) begin : rsp_monitor
    outcome_t    want;
    int unsigned next_wait;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rsp_wait     <= 0;
      rsp_count    <= 0;
    end else begin
      next_wait = rsp_wait;
      if (rsp_if.valid && rsp_if.ready) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected response: status %0d slot_index %0d",
                 rsp_if.status, rsp_if.slot_index);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            errors++;
          end
          if (rsp_if.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d",
                   want.slot_index, rsp_if.slot_index);
            errors++;
          end
        end
        rsp_count <= rsp_count + 1;
        // one long hold-off lets the block fill up and stall its input
        next_wait = (rsp_count == HoldAtRsp) ? LongHold : draw_rsp_wait();
      end
      if (next_wait != 0) begin
        rsp_if.ready <= 1'b0;
        rsp_wait     <= next_wait - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        rsp_wait     <= 0;
      end
    end
  end

  // Watchdog: cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Stimulus, reset and end of run
  initial begin
    logic [KeyW-1:0] k;
    logic [OpW-1:0]  op;
    int unsigned     roll;
    int unsigned     insert_pct;
    bit              timed_out;
    bit              responses_missing;

    rst_ni            = 1'b0;
    insert_pct        = 50;
    timed_out         = 1'b0;
    responses_missing = 1'b0;

    // directed: zero key, undefined opcode, absent keys, wrap, duplicates
    add_request(OP_INSERT, '0);
    add_request(OP_SEARCH, '0);
    add_request(OP_DELETE, '0);
    add_request(OpUndefined, '0);
    add_request(OpUndefined, 32'h0000_0005);
    add_request(OpUndefined, 32'hFFFF_FFFF);
    add_request(OP_SEARCH, 32'hFFFF_FFFF);
    add_request(OP_DELETE, 32'hFFFF_FFFF);
    add_request(OP_INSERT, 32'hFFFF_FFFF);
    add_request(OP_INSERT, 32'hFFFF_FFFF);
    add_request(OP_INSERT, 32'h0000_0010);
    add_request(OP_SEARCH, 32'h0000_0010);
    add_request(OP_DELETE, 32'hFFFF_FFFF);
    add_request(OP_SEARCH, 32'hFFFF_FFFF);
    add_request(OP_INSERT, 32'h0000_0001);
    add_request(OP_DELETE, 32'hFFFF_FFFF);
    add_request(OP_SEARCH, 32'hFFFF_FFFF);
    add_request(OP_DELETE, 32'h0000_0010);
    add_request(OP_DELETE, 32'h0000_0001);
    add_request(OP_INSERT, 32'h8000_0000);
    add_request(OP_SEARCH, 32'h8000_0000);
    add_request(OP_DELETE, 32'h8000_0000);

    // key pool; half of it clusters on a few home slots, some near the wrap
    foreach (key_pool[i]) begin
      k = $urandom;
      if (i < KeyPoolSize / 4) k[3:0] = 4'($urandom_range(0, 2));
      else if (i < KeyPoolSize / 2) k[3:0] = 4'hE + 4'($urandom_range(0, 1));
      if (k == '0) k = 32'h0001_0000;
      key_pool[i] = k;
    end

    // random: mostly pool keys so that inserts, hits and deletes interact
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n % 100 == 0) insert_pct = $urandom_range(20, 65);
      if (n % 64 == 0) req_fast = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        add_request(OpW'($urandom_range(0, 2)), '0);
      end else if (roll < 4) begin
        add_request(OpUndefined, $urandom);
      end else if (roll < 10) begin
        add_request(($urandom_range(0, 1) == 0) ? OP_SEARCH : OP_DELETE, $urandom);
      end else begin
        k    = key_pool[$urandom_range(0, KeyPoolSize - 1)];
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) op = OP_INSERT;
        else if (roll < insert_pct + (100 - insert_pct) / 2) op = OP_SEARCH;
        else op = OP_DELETE;
        add_request(op, k);
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every request to be taken and every response to arrive
    while ((request_q.size() != 0 || req_if.valid || outcome_q.size() != 0) &&
           idle_cycles < StallLimit)
      @(posedge clk_i);
    if (idle_cycles >= StallLimit) timed_out = 1'b1;
    repeat (DrainCycles) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      $error("%0d responses never arrived", outcome_q.size());
      responses_missing = 1'b1;
    end

    if (errors == 0 && !timed_out && !responses_missing)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
